@@ sv/fsk_dibit_symbol_sequencer_core_defines.svh @@
// assertion macros shared by the fsk dibit symbol sequencer rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef FSK_DIBIT_SYMBOL_SEQUENCER_CORE_DEFINES_SVH
`define FSK_DIBIT_SYMBOL_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fds_pkg.sv @@
// shared types, constants and message rom for the fsk dibit symbol sequencer
// no dependencies
package fds_pkg;

  localparam int TIME_W          = 32;
  localparam int POS_W           = 7;
  localparam int TONE_W          = 3;
  localparam int CFG_ADDR_W      = 2;
  localparam int MESSAGE_LENGTH  = 11;
  localparam int ROM_DEPTH       = 16;
  localparam int CHAR_STEP_COUNT = 8;
  localparam logic [POS_W-1:0] SEQ_STEP_COUNT =
    POS_W'(2 + MESSAGE_LENGTH * CHAR_STEP_COUNT);

  // tone codes
  localparam logic [TONE_W-1:0] TONE_IDLE       = 3'd0;
  localparam logic [TONE_W-1:0] TONE_SEND       = 3'd1;
  localparam logic [TONE_W-1:0] TONE_DIBIT_BASE = 3'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PREAMBLE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOL   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT   = 2'd2;

  // register reset values
  localparam logic [TIME_W-1:0] PREAMBLE_RST = 32'd500000;
  localparam logic [TIME_W-1:0] SYMBOL_RST   = 32'd100000;
  localparam logic [TIME_W-1:0] REPEAT_RST   = 32'd2000000;

  // message text, unused entries zero
  localparam logic [7:0] MESSAGE_ROM [ROM_DEPTH] = '{
    8'h48, 8'h65, 8'h6C, 8'h6C, 8'h6F, 8'h20, 8'h57, 8'h6F,
    8'h72, 8'h6C, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [TIME_W-1:0] preamble_us;
    logic [TIME_W-1:0] symbol_us;
    logic [TIME_W-1:0] repeat_us;
  } fds_cfg_t;

  typedef struct packed {
    logic              hit;
    logic [TONE_W-1:0] tone_code;
    logic              ended;
  } fds_result_t;

  // leading step or trailing step (and anything beyond)
  function automatic logic fds_is_idle(input logic [POS_W-1:0] pos);
    return (pos == '0) || (pos >= SEQ_STEP_COUNT - POS_W'(1));
  endfunction

endpackage

@@ sv/fds_tone_lut.sv @@
// maps a step position to its tone code using the message rom
// depends on fds_pkg
module fds_tone_lut (
  input  logic [fds_pkg::POS_W-1:0]  pos,
  output logic [fds_pkg::TONE_W-1:0] tone_code
);

  logic [fds_pkg::POS_W-1:0] inner;
  logic [3:0]                ch;
  logic [2:0]                sub;
  logic [7:0]                char_bits;
  logic [1:0]                dibit;

  // character and sub-step within the character
  assign inner     = pos - fds_pkg::POS_W'(1);
  assign ch        = inner[6:3];
  assign sub       = inner[2:0];
  assign char_bits = fds_pkg::MESSAGE_ROM[ch];

  // dibits least significant first
  always_comb begin
    case (sub[2:1])
      2'd0:    dibit = char_bits[1:0];
      2'd1:    dibit = char_bits[3:2];
      2'd2:    dibit = char_bits[5:4];
      2'd3:    dibit = char_bits[7:6];
      default: dibit = char_bits[1:0];
    endcase
  end

  always_comb begin
    if (fds_pkg::fds_is_idle(pos)) begin
      tone_code = fds_pkg::TONE_IDLE;
    end else if (!sub[0]) begin
      tone_code = fds_pkg::TONE_SEND;
    end else begin
      tone_code = fds_pkg::TONE_DIBIT_BASE + {1'b0, dibit};
    end
  end

endmodule

@@ sv/fds_step_ctrl.sv @@
// step position, step timing and repeat wait state with the per-tick decision
// depends on fds_pkg, fds_tone_lut and the assertion macro header
`include "fsk_dibit_symbol_sequencer_core_defines.svh"

module fds_step_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_fire,
  input  logic [fds_pkg::TIME_W-1:0]  time_now_us,
  input  fds_pkg::fds_cfg_t           cfg,
  output fds_pkg::fds_result_t        result
);

  logic [fds_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [fds_pkg::TIME_W-1:0] step_begin_r, step_begin_nxt;
  logic                       wait_r, wait_nxt;
  logic [fds_pkg::TIME_W-1:0] repeat_begin_r, repeat_begin_nxt;

  logic [fds_pkg::TIME_W-1:0] step_elapsed;
  logic [fds_pkg::TIME_W-1:0] repeat_elapsed;
  logic [fds_pkg::TIME_W-1:0] step_dur;
  logic [fds_pkg::POS_W:0]    next_pos_wide;
  logic [fds_pkg::POS_W-1:0]  next_pos;
  logic [fds_pkg::TONE_W-1:0] next_tone;
  logic                       step_done;
  logic                       repeat_done;
  logic                       seq_end;

  // wrapping elapsed times
  assign step_elapsed   = time_now_us - step_begin_r;
  assign repeat_elapsed = time_now_us - repeat_begin_r;
  assign step_dur       = fds_pkg::fds_is_idle(pos_r) ? cfg.preamble_us : cfg.symbol_us;
  assign step_done      = step_elapsed >= step_dur;
  assign repeat_done    = repeat_elapsed >= cfg.repeat_us;

  assign next_pos_wide = {1'b0, pos_r} + (fds_pkg::POS_W+1)'(1);
  assign next_pos      = next_pos_wide[fds_pkg::POS_W-1:0];
  assign seq_end       = next_pos_wide >= {1'b0, fds_pkg::SEQ_STEP_COUNT};

  fds_tone_lut u_tone (
    .pos       (next_pos),
    .tone_code (next_tone)
  );

  // decision for the tick held at the input
  always_comb begin
    result           = '0;
    pos_nxt          = pos_r;
    step_begin_nxt   = step_begin_r;
    wait_nxt         = wait_r;
    repeat_begin_nxt = repeat_begin_r;
    if (wait_r) begin
      if (repeat_done) begin
        result.hit     = 1'b1;
        result.tone_code = fds_pkg::TONE_IDLE;
        pos_nxt        = '0;
        step_begin_nxt = time_now_us;
        wait_nxt       = 1'b0;
      end
    end else if (step_done) begin
      result.hit = 1'b1;
      pos_nxt    = next_pos;
      if (!seq_end) begin
        result.tone_code = next_tone;
        step_begin_nxt   = time_now_us;
      end else begin
        result.tone_code = fds_pkg::TONE_IDLE;
        result.ended     = 1'b1;
        wait_nxt         = 1'b1;
        repeat_begin_nxt = time_now_us;
      end
    end
  end

  // state update on each consumed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= '0;
      step_begin_r   <= '0;
      wait_r         <= 1'b0;
      repeat_begin_r <= '0;
    end else if (tick_fire) begin
      pos_r          <= pos_nxt;
      step_begin_r   <= step_begin_nxt;
      wait_r         <= wait_nxt;
      repeat_begin_r <= repeat_begin_nxt;
    end
  end

  `FDS_ASSERT_NOW(a_wait_at_end, wait_r, pos_r == fds_pkg::SEQ_STEP_COUNT, "wait outside end step")
  `FDS_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= fds_pkg::SEQ_STEP_COUNT, "step position out of range")
  `FDS_ASSERT_NOW(a_end_idle, result.ended, result.hit && result.tone_code == fds_pkg::TONE_IDLE,
    "sequence end without idle tone")
  `FDS_ASSERT_NEXT(a_end_waits, tick_fire && result.ended, wait_r && pos_r == fds_pkg::SEQ_STEP_COUNT,
    "sequence end did not enter repeat wait")

endmodule

@@ sv/fsk_dibit_symbol_sequencer_core.sv @@
// fsk dibit symbol sequencer top level: input register, step control, result register
// depends on fds_pkg and fds_step_ctrl
// a result passes through the input register and then the result register before it shows on out_*
// throughput: one time stamp per cycle unless a full result register with out_tready low stalls it
// a tick that sets no tone gives no result; out_tready low stalls the input
// reset (rst_n low, synchronous): step zero timed from 0, registers to defaults
module fsk_dibit_symbol_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] time_now_us
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [2:0] tone_code, [7:3] zero
  output logic                            out_tlast,  // sequence_ended
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [fds_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [31:0]                     cfg_wdata
);

  fds_pkg::fds_cfg_t          cfg_r;
  logic                       in_v_r;
  logic [fds_pkg::TIME_W-1:0] in_time_r;
  logic                       out_v_r;
  logic [fds_pkg::TONE_W-1:0] out_tone_r;
  logic                       out_end_r;

  fds_pkg::fds_result_t result;
  logic                 out_space;
  logic                 tick_fire;
  logic                 in_xfer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_us <= fds_pkg::PREAMBLE_RST;
      cfg_r.symbol_us   <= fds_pkg::SYMBOL_RST;
      cfg_r.repeat_us   <= fds_pkg::REPEAT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        fds_pkg::CFG_PREAMBLE: cfg_r.preamble_us <= cfg_wdata;
        fds_pkg::CFG_SYMBOL:   cfg_r.symbol_us   <= cfg_wdata;
        fds_pkg::CFG_REPEAT:   cfg_r.repeat_us   <= cfg_wdata;
        default:               cfg_r             <= cfg_r;
      endcase
    end
  end

  // a held tick moves on when it gives no result or the result register frees up
  assign out_space = !out_v_r || out_tready;
  assign tick_fire = in_v_r && (!result.hit || out_space);
  assign in_tready = !in_v_r || tick_fire;
  assign in_xfer   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_xfer) begin
      in_v_r <= 1'b1;
    end else if (tick_fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_time_r <= in_tdata;
    end
  end

  fds_step_ctrl u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_fire   (tick_fire),
    .time_now_us (in_time_r),
    .cfg         (cfg_r),
    .result      (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (tick_fire && result.hit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire && result.hit) begin
      out_tone_r <= result.tone_code;
      out_end_r  <= result.ended;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_tone_r};
  assign out_tlast  = out_end_r;

endmodule

@@ dv/fsk_dibit_symbol_sequencer_core_tb.sv @@
// self-checking testbench for the fsk dibit symbol sequencer core
// depends on fds_pkg and fsk_dibit_symbol_sequencer_core; predicts tone changes per time stamp
`timescale 1ns / 100ps

module fsk_dibit_symbol_sequencer_core_tb;

  localparam int SEQ_STEPS     = 2 + fds_pkg::MESSAGE_LENGTH * fds_pkg::CHAR_STEP_COUNT;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 130;
  localparam int PHASE_COUNT   = 8;
  localparam logic [fds_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic [0:0] {ROW_TICK, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TONE} row_check_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  tone;
    logic        ended;
  } tone_change_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [fds_pkg::CFG_ADDR_W-1:0]  addr;
    logic [31:0]                     value;
    row_check_t                      check;
    logic [2:0]                      tone;
    logic                            ended;
  } dir_row_t;

  // directed stimulus: reset start, wrap-around timing, zero durations, ignored register
  localparam dir_row_t DIRECTED [21] = '{
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'h0000_0000, CHK_QUIET, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'hFFFF_FFFF, CHK_TONE,  fds_pkg::TONE_SEND, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'd99998,     CHK_QUIET, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'd99999,     CHK_TONE,
      fds_pkg::TONE_DIBIT_BASE, 1'b0},
    '{ROW_CFG,  fds_pkg::CFG_SYMBOL,   32'hFFFF_FFFF, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'd99997,     CHK_QUIET, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'd99998,     CHK_TONE,  fds_pkg::TONE_SEND, 1'b0},
    '{ROW_CFG,  fds_pkg::CFG_PREAMBLE, 32'h0000_0000, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_CFG,  fds_pkg::CFG_SYMBOL,   32'h0000_0000, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_CFG,  fds_pkg::CFG_REPEAT,   32'h0000_0000, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_CFG,  CFG_UNUSED,            32'hFFFF_FFFF, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'd99998,     CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'd12345678,  CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'h0000_0000, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'h8000_0000, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'h7FFF_FFFF, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'd5,         CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'd5,         CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'hAAAA_AAAA, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'h5555_5555, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0},
    '{ROW_TICK, fds_pkg::CFG_PREAMBLE, 32'hFFFF_FFFF, CHK_MODEL, fds_pkg::TONE_IDLE, 1'b0}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [31:0]                     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [7:0]                      out_tdata;
  logic                            out_tlast;
  logic                            cfg_wr_en = 1'b0;
  logic [fds_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [31:0]                     cfg_wdata = '0;

  // predictor state and register copies
  logic [31:0]  pre_us, sym_us, rep_us;
  logic [6:0]   cur_step;
  logic [31:0]  step_start, wait_start, last_time;
  logic         in_repeat_wait;

  tone_change_t tone_changes_due [$];
  idle_mode_t   idle_mode = IDLE_NONE;
  logic         pressure_req = 1'b0;
  logic         pressure_seen = 1'b0;
  int           hold_left = 0;
  int           fail_count = 0;
  int           items_sent = 0;
  int           changes_seen = 0;
  int           ends_seen = 0;

  fsk_dibit_symbol_sequencer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] time_now_us
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [2:0] tone_code, [7:3] zero
    .out_tlast  (out_tlast),   // sequence_ended
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("[fsk_dibit_symbol_sequencer_core] ERROR");
    $finish;
  end

  function automatic logic is_rest_step(input logic [6:0] p);
    return (p == 7'd0) || (int'(p) >= SEQ_STEPS - 1);
  endfunction

  function automatic logic [31:0] step_len(input logic [6:0] p);
    return is_rest_step(p) ? pre_us : sym_us;
  endfunction

  // tone of a step: marker on even sub-steps, dibit of the character lsb first on odd ones
  function automatic logic [2:0] step_tone(input logic [6:0] p);
    logic [6:0] inner;
    logic [7:0] chr;
    logic [1:0] dibit;
    if (is_rest_step(p)) return fds_pkg::TONE_IDLE;
    inner = p - 7'd1;
    if (!inner[0]) return fds_pkg::TONE_SEND;
    chr = fds_pkg::MESSAGE_ROM[inner[6:3]];
    dibit = 2'((chr >> (2 * inner[2:1])) & 8'h03);
    return fds_pkg::TONE_DIBIT_BASE + 3'(dibit);
  endfunction

  // advance the predicted sequencer by one time stamp
  function automatic tone_change_t predict_tick(input logic [31:0] now);
    tone_change_t res;
    logic [31:0]  elapsed;
    int           nxt;
    res = '0;
    last_time = now;
    if (in_repeat_wait) begin
      elapsed = now - wait_start;
      if (elapsed >= rep_us) begin
        cur_step = 7'd0;
        step_start = now;
        in_repeat_wait = 1'b0;
        res = '{hit: 1'b1, tone: step_tone(7'd0), ended: 1'b0};
      end
      return res;
    end
    elapsed = now - step_start;
    if (elapsed >= step_len(cur_step)) begin
      nxt = int'(cur_step) + 1;
      cur_step = 7'(nxt);
      if (nxt < SEQ_STEPS) begin
        step_start = now;
        res = '{hit: 1'b1, tone: step_tone(cur_step), ended: 1'b0};
      end else begin
        in_repeat_wait = 1'b1;
        wait_start = now;
        res = '{hit: 1'b1, tone: fds_pkg::TONE_IDLE, ended: 1'b1};
      end
    end
    return res;
  endfunction

  function automatic int sender_gap_pct();
    case (idle_mode)
      IDLE_SENDER: return 45;
      IDLE_BOTH:   return 22;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 45;
      IDLE_BOTH:     return 22;
      default:       return 0;
    endcase
  endfunction

  // random time stamp: mostly near the current deadline, some small steps, some noise
  function automatic logic [31:0] pick_time();
    int unsigned sel;
    logic [31:0] base, span;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      base = in_repeat_wait ? wait_start : step_start;
      span = in_repeat_wait ? rep_us : step_len(cur_step);
      return base + span + 32'($urandom_range(0, 4)) - 32'd2;
    end else if (sel < 85) begin
      return last_time + 32'($urandom_range(0, 3));
    end
    return 32'($urandom());
  endfunction

  // offer one time stamp, return the predicted change once the transfer happens
  task automatic send_time(input logic [31:0] t, output tone_change_t res);
    while ($urandom_range(0, 99) < sender_gap_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
    res = predict_tick(t);
    items_sent++;
  endtask

  // register write once the block has gone quiet
  task automatic write_reg(input logic [fds_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (tone_changes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (addr)
      fds_pkg::CFG_PREAMBLE: pre_us = value;
      fds_pkg::CFG_SYMBOL:   sym_us = value;
      fds_pkg::CFG_REPEAT:   rep_us = value;
      default: ;
    endcase
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (pressure_req && !pressure_seen) begin
      pressure_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // result checker
  always @(posedge clk) begin
    tone_change_t due;
    if (rst_n && out_tvalid && out_tready) begin
      changes_seen++;
      if (out_tlast) ends_seen++;
      if (tone_changes_due.size() == 0) begin
        $error("unexpected result transfer: tone_code %0d, sequence_ended %0d",
               out_tdata, out_tlast);
        fail_count++;
      end else begin
        due = tone_changes_due.pop_front();
        if (out_tdata !== {5'b0, due.tone}) begin
          $error("tone_code mismatch: expected %0d, actual %0d", due.tone, out_tdata);
          fail_count++;
        end
        if (out_tlast !== due.ended) begin
          $error("sequence_ended mismatch: expected %0d, actual %0d", due.ended, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    tone_change_t res;
    logic [31:0]  p_val, s_val, r_val;
    pre_us = fds_pkg::PREAMBLE_RST;
    sym_us = fds_pkg::SYMBOL_RST;
    rep_us = fds_pkg::REPEAT_RST;
    cur_step = '0;
    step_start = '0;
    wait_start = '0;
    last_time = '0;
    in_repeat_wait = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_reg(DIRECTED[i].addr, DIRECTED[i].value);
      end else begin
        send_time(DIRECTED[i].value, res);
        case (DIRECTED[i].check)
          CHK_TONE:  tone_changes_due.push_back(
                       tone_change_t'{1'b1, DIRECTED[i].tone, DIRECTED[i].ended});
          CHK_QUIET: ;
          default:   if (res.hit) tone_changes_due.push_back(res);
        endcase
      end
    end

    // random phases, each with a register setting and one of four idling patterns
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          p_val = fds_pkg::PREAMBLE_RST;
          s_val = fds_pkg::SYMBOL_RST;
          r_val = fds_pkg::REPEAT_RST;
        end
        1: begin p_val = 32'd0; s_val = 32'd0; r_val = 32'd0; end
        2: begin p_val = 32'hFFFF_FFFF; s_val = 32'hFFFF_FFFF; r_val = 32'hFFFF_FFFF; end
        3: begin p_val = 32'd3; s_val = 32'd2; r_val = 32'd5; end
        4: begin p_val = 32'd1; s_val = 32'd0; r_val = 32'hFFFF_FFFF; end
        5: begin p_val = $urandom(); s_val = $urandom(); r_val = $urandom(); end
        6: begin p_val = 32'd0; s_val = 32'hFFFF_FFFF; r_val = 32'd0; end
        default: begin
          p_val = $urandom_range(0, 20);
          s_val = $urandom_range(0, 20);
          r_val = $urandom_range(0, 20);
        end
      endcase
      write_reg(fds_pkg::CFG_PREAMBLE, p_val);
      write_reg(fds_pkg::CFG_SYMBOL, s_val);
      write_reg(fds_pkg::CFG_REPEAT, r_val);
      if (ph == 5) write_reg(CFG_UNUSED, $urandom());
      idle_mode = idle_mode_t'(ph % 4);
      if (ph == 4) pressure_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        send_time(pick_time(), res);
        if (res.hit) tone_changes_due.push_back(res);
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (tone_changes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("run covered %0d time stamps over %0d register settings", items_sent,
             PHASE_COUNT + 1);
    $display("saw %0d tone changes, %0d of them ending the sequence", changes_seen, ends_seen);
    if (fail_count == 0) begin
      $display("[fsk_dibit_symbol_sequencer_core] OK");
    end else begin
      $display("[fsk_dibit_symbol_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/fds_pkg.sv
sv/fds_tone_lut.sv
sv/fds_step_ctrl.sv
sv/fsk_dibit_symbol_sequencer_core.sv
dv/fsk_dibit_symbol_sequencer_core_tb.sv
